FILE: src/fmbq_pkg.sv
// Package for the front/middle/back queue: operation and status codes.
// No dependencies; used by src/front_middle_back_queue.sv.
`default_nettype none

package fmbq_pkg;

  typedef enum logic [2:0] {
    KIND_PUSH_FRONT  = 3'd0,
    KIND_PUSH_MIDDLE = 3'd1,
    KIND_PUSH_BACK   = 3'd2,
    KIND_POP_FRONT   = 3'd3,
    KIND_POP_MIDDLE  = 3'd4,
    KIND_POP_BACK    = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  localparam int unsigned VALUE_W = 32;

endpackage

`default_nettype wire

FILE: src/front_middle_back_queue.sv
// Front/middle/back queue: a row of DEPTH shifting cells with an occupancy count.
// Depends on fmbq_pkg for operation and status codes.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid, in_stall, in_kind, in_value   | into block
//   out     | out_valid, out_stall, out_popped_value, | out of block
//           | out_status                              |
//
// One beat per cycle while out is not stalled: an accepted beat waits in the input stage,
// then the queue update and the result register load together at the edge on which it
// fires. The cell row and the occupancy count update together at that edge, which sets
// the rate of one operation per clock while out is not stalled.
// Synchronous active-low reset clears the occupancy count and the valid flags;
// the cells hold unknown data until written.
// A stall on out holds the result; the input stage then fills and stalls in.
`default_nettype none

module front_middle_back_queue #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [2:0]                          in_kind,
  input  wire logic signed [fmbq_pkg::VALUE_W-1:0] in_value,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [fmbq_pkg::VALUE_W-1:0]      out_popped_value,
  output logic [1:0]                               out_status
);

  localparam int unsigned OCC_W = $clog2(DEPTH + 1);

  // input stage
  logic                                stg_valid_r;
  logic [2:0]                          stg_kind_r;
  logic signed [fmbq_pkg::VALUE_W-1:0] stg_value_r;

  // queue state
  logic signed [fmbq_pkg::VALUE_W-1:0] cell_r   [DEPTH];
  logic signed [fmbq_pkg::VALUE_W-1:0] cell_nxt [DEPTH];
  logic [OCC_W-1:0]                    occ_r;
  logic [OCC_W-1:0]                    occ_nxt;

  // result register
  logic                                out_valid_r;
  logic signed [fmbq_pkg::VALUE_W-1:0] out_value_r;
  logic signed [fmbq_pkg::VALUE_W-1:0] out_value_nxt;
  fmbq_pkg::status_t                   out_status_r;
  fmbq_pkg::status_t                   out_status_nxt;

  logic             fire;
  logic             is_push;
  logic             is_pop;
  logic             q_full;
  logic             q_empty;
  logic             do_push;
  logic             do_pop;
  logic [OCC_W-1:0] pos;

  assign fire     = stg_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = stg_valid_r && !fire;

  assign q_full  = (occ_r == OCC_W'(DEPTH));
  assign q_empty = (occ_r == '0);

  // decode the operation and its position from the occupancy alone
  always_comb begin
    is_push = 1'b0;
    is_pop  = 1'b0;
    pos     = '0;
    unique case (stg_kind_r)
      fmbq_pkg::KIND_PUSH_FRONT: begin
        is_push = 1'b1;
      end
      fmbq_pkg::KIND_PUSH_MIDDLE: begin
        is_push = 1'b1;
        pos     = occ_r >> 1;
      end
      fmbq_pkg::KIND_PUSH_BACK: begin
        is_push = 1'b1;
        pos     = occ_r;
      end
      fmbq_pkg::KIND_POP_FRONT: begin
        is_pop = 1'b1;
      end
      fmbq_pkg::KIND_POP_MIDDLE: begin
        is_pop = 1'b1;
        pos    = (occ_r - OCC_W'(1)) >> 1;
      end
      fmbq_pkg::KIND_POP_BACK: begin
        is_pop = 1'b1;
        pos    = occ_r - OCC_W'(1);
      end
      default: begin
        // unused codes: no change, status done
      end
    endcase
  end

  assign do_push = is_push && !q_full;
  assign do_pop  = is_pop && !q_empty;

  // each cell picks its own value, its neighbor toward the front, its neighbor
  // toward the back, or the new value
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [OCC_W-1:0] CI = OCC_W'(i);
    logic signed [fmbq_pkg::VALUE_W-1:0] from_prev;
    logic signed [fmbq_pkg::VALUE_W-1:0] from_next;

    if (i == 0) begin : g_first
      assign from_prev = cell_r[i];
    end else begin : g_prev
      assign from_prev = cell_r[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign from_next = cell_r[i];
    end else begin : g_next
      assign from_next = cell_r[i+1];
    end

    always_comb begin
      cell_nxt[i] = cell_r[i];
      if (do_push) begin
        if (CI == pos) begin
          cell_nxt[i] = stg_value_r;
        end else if (CI > pos) begin
          cell_nxt[i] = from_prev;
        end
      end else if (do_pop) begin
        if (CI >= pos) begin
          cell_nxt[i] = from_next;
        end
      end
    end
  end

  always_comb begin
    occ_nxt = occ_r;
    if (do_push) begin
      occ_nxt = occ_r + OCC_W'(1);
    end else if (do_pop) begin
      occ_nxt = occ_r - OCC_W'(1);
    end
  end

  // result: popped cell or zero, and the status
  always_comb begin
    out_value_nxt = '0;
    if (do_pop) begin
      for (int unsigned j = 0; j < DEPTH; j++) begin
        if (OCC_W'(j) == pos) begin
          out_value_nxt = cell_r[j];
        end
      end
    end
    out_status_nxt = fmbq_pkg::STATUS_DONE;
    if (is_push && q_full) begin
      out_status_nxt = fmbq_pkg::STATUS_FULL;
    end else if (is_pop && q_empty) begin
      out_status_nxt = fmbq_pkg::STATUS_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      occ_r       <= '0;
    end else begin
      if (!in_stall) begin
        stg_valid_r <= in_valid;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
        occ_r       <= occ_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stg_kind_r  <= in_kind;
      stg_value_r <= in_value;
    end
    if (fire) begin
      out_value_r  <= out_value_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      for (int unsigned k = 0; k < DEPTH; k++) begin
        cell_r[k] <= cell_nxt[k];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = out_value_r;
  assign out_status       = out_status_r;

  // checks
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(DEPTH))
    else $error("occupancy beyond capacity");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != fmbq_pkg::STATUS_DONE) |-> out_value_r == '0)
    else $error("failed operation returned a nonzero value");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    fire && do_push |=> occ_r == $past(occ_r) + OCC_W'(1))
    else $error("push did not grow occupancy");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    fire && do_pop |=> occ_r == $past(occ_r) - OCC_W'(1))
    else $error("pop did not shrink occupancy");

endmodule

`default_nettype wire
